[src/tlv_pkg.sv]
package tlv_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned LenW    = 16;
	localparam int unsigned ValueW  = 64;
	localparam int unsigned KindW   = 2;
	localparam int unsigned NibW    = 4;
	localparam int unsigned PhaseW  = 2;
	localparam int unsigned LenCntW = 2;

	localparam logic [PhaseW-1:0] PH_HEADER  = 2'd0;
	localparam logic [PhaseW-1:0] PH_LENGTH  = 2'd1;
	localparam logic [PhaseW-1:0] PH_PAYLOAD = 2'd2;
	localparam logic [PhaseW-1:0] PH_VALUE   = 2'd3;

	localparam logic [KindW-1:0] K_PAYLOAD = 2'd0;
	localparam logic [KindW-1:0] K_EMPTY   = 2'd1;
	localparam logic [KindW-1:0] K_UINT    = 2'd2;
	localparam logic [KindW-1:0] K_BAD     = 2'd3;

	localparam logic [NibW-1:0] TYPE_BYTES = 4'd0;
	localparam logic [NibW-1:0] TYPE_UINT  = 4'd1;

	typedef struct packed {
		logic [KindW-1:0]  kind;
		logic [ByteW-1:0]  data_byte;
		logic [ValueW-1:0] uint_value;
		logic [LenW-1:0]   payload_length;
		logic              last_of_element;
	} result_t;

endpackage

[src/tlv_if.sv]
interface tlv_in_if
	import tlv_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

interface tlv_out_if
	import tlv_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KindW-1:0]  kind;
	logic [ByteW-1:0]  data_byte;
	logic [ValueW-1:0] uint_value;
	logic [LenW-1:0]   payload_length;
	logic              last_of_element;

	modport source (output valid, output kind, output data_byte, output uint_value,
		output payload_length, output last_of_element, input ready);
	modport sink (input valid, input kind, input data_byte, input uint_value,
		input payload_length, input last_of_element, output ready);
endinterface

[src/tlv_stream_decoder.sv]
// A byte passes through the input register and then the result register before its result (if any) reaches the output.
// Throughput: one byte per cycle while the result side keeps ready high.
// The input register and the result register are the only stages; the decode state
// (phase, counters, accumulators) is updated as a byte leaves the input register.
// Reset (arst_n low, asynchronous) empties both stages and returns the parser to the header.
module tlv_stream_decoder
	import tlv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tlv_in_if.sink     stream,
	tlv_out_if.source  result
);

	logic                 valid_s1;
	logic [ByteW-1:0]     byte_s1;
	logic                 fire_s1;

	logic [PhaseW-1:0]    phase_q, phase_n;
	logic [LenCntW-1:0]   len_left_q, len_left_n;
	logic [LenW-1:0]      len_acc_q, len_acc_n;
	logic [LenW-1:0]      pay_left_q, pay_left_n;
	logic [ValueW-1:0]    val_acc_q, val_acc_n;
	logic [NibW-1:0]      val_left_q, val_left_n;

	logic                 emit;
	result_t              res_n, res_q;
	logic                 out_valid_q;

	logic [NibW-1:0]      lo, hi;

	assign fire_s1      = valid_s1 && (!out_valid_q || result.ready);
	assign stream.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.stream_byte;
		end
	end

	assign lo = byte_s1[NibW-1:0];
	assign hi = byte_s1[ByteW-1:NibW];

	always_comb begin
		phase_n    = phase_q;
		len_left_n = len_left_q;
		len_acc_n  = len_acc_q;
		pay_left_n = pay_left_q;
		val_acc_n  = val_acc_q;
		val_left_n = val_left_q;
		emit       = 1'b0;
		res_n      = '0;
		res_n.last_of_element = 1'b1;
		case (phase_q)
			PH_HEADER: begin
				if (lo == TYPE_BYTES) begin
					if (hi == 4'd1 || hi == 4'd2) begin
						len_left_n = hi[LenCntW-1:0];
						len_acc_n  = '0;
						phase_n    = PH_LENGTH;
					end else begin
						emit       = 1'b1;
						res_n.kind = K_BAD;
					end
				end else if (lo == TYPE_UINT) begin
					if (hi == '0) begin
						emit       = 1'b1;
						res_n.kind = K_UINT;
					end else begin
						val_left_n = hi;
						val_acc_n  = '0;
						phase_n    = PH_VALUE;
					end
				end else begin
					emit       = 1'b1;
					res_n.kind = K_BAD;
				end
			end
			PH_LENGTH: begin
				len_acc_n  = {len_acc_q[LenW-ByteW-1:0], byte_s1};
				len_left_n = len_left_q - 1'b1;
				if (len_left_n == '0) begin
					if (len_acc_n == '0) begin
						emit       = 1'b1;
						res_n.kind = K_EMPTY;
						phase_n    = PH_HEADER;
					end else begin
						pay_left_n = len_acc_n;
						phase_n    = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				emit                  = 1'b1;
				res_n.kind            = K_PAYLOAD;
				res_n.data_byte       = byte_s1;
				res_n.payload_length  = len_acc_q;
				res_n.last_of_element = (pay_left_q <= LenW'(1));
				pay_left_n            = pay_left_q - 1'b1;
				if (res_n.last_of_element) begin
					phase_n = PH_HEADER;
				end
			end
			PH_VALUE: begin
				val_acc_n  = {val_acc_q[ValueW-ByteW-1:0], byte_s1};
				val_left_n = val_left_q - 1'b1;
				if (val_left_n == '0) begin
					emit             = 1'b1;
					res_n.kind       = K_UINT;
					res_n.uint_value = val_acc_n;
					phase_n          = PH_HEADER;
				end
			end
			default: begin
				phase_n = PH_HEADER;
			end
		endcase
	end

	// advance decode state only when the byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			len_left_q <= '0;
			len_acc_q  <= '0;
			pay_left_q <= '0;
			val_acc_q  <= '0;
			val_left_q <= '0;
		end else if (fire_s1) begin
			phase_q    <= phase_n;
			len_left_q <= len_left_n;
			len_acc_q  <= len_acc_n;
			pay_left_q <= pay_left_n;
			val_acc_q  <= val_acc_n;
			val_left_q <= val_left_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= emit;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			res_q <= res_n;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.kind            = res_q.kind;
	assign result.data_byte       = res_q.data_byte;
	assign result.uint_value      = res_q.uint_value;
	assign result.payload_length  = res_q.payload_length;
	assign result.last_of_element = res_q.last_of_element;

`ifndef NO_ASSERTIONS
	a_len_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LENGTH |-> len_left_q != '0)
		else $error("length phase with no length bytes left");

	a_val_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VALUE |-> val_left_q != '0)
		else $error("value phase with no value bytes left");

	a_pay_left_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pay_left_q != '0)
		else $error("payload phase with no payload bytes left");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind != K_PAYLOAD |-> res_q.last_of_element)
		else $error("non-payload result without last flag");

	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == K_PAYLOAD |-> res_q.payload_length != '0)
		else $error("payload transfer of a zero-length string");
`endif

endmodule
